### src/cffc_pkg.sv
// ----------------------------------------------------------------------------
// cffc_pkg: shared types and helpers of the frequency format converter
// Holds the payload that moves along the cell chain, the operation codes and
// the small arithmetic helpers that the cells and the output stage use.
// ----------------------------------------------------------------------------
package cffc_pkg;

   // One cell for each shift-and-add-3 step of the binary to BCD direction.
   localparam int CellCount = 27;
   // Only the seven lower digits can still take a carry during the shifts.
   localparam int AdjDigits = 7;
   // Number of packed BCD bytes in a frequency.
   localparam int BcdBytes = 4;
   // Counts of tens of hertz at or above this value do not fit eight digits.
   localparam logic [31:0] LimitTens = 32'd100000000;

   typedef enum logic {
      OP_TO_BCD = 1'b0,
      OP_TO_BIN = 1'b1
   } op_type;

   // Work item as it travels from cell to cell.
   typedef struct packed {
      op_type      op;
      logic        too_large;
      logic [2:0]  bytes_left;   // BCD bytes still to be folded in (BCD to binary)
      logic [31:0] value;        // source bits, consumed from the top
      logic [31:0] acc;          // BCD digits, or the binary sum
   } cell_data_type;

   // Arithmetic weight of one packed byte: high nibble times ten plus low nibble.
   function automatic logic [7:0] pair_value(input logic [7:0] pair);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'd0, pair[7:4]};
      lo = {4'd0, pair[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   function automatic logic [31:0] times100(input logic [31:0] x);
      return (x << 6) + (x << 5) + (x << 2);
   endfunction

   function automatic logic [30:0] times10(input logic [30:0] x);
      return (x << 3) + (x << 1);
   endfunction

endpackage

### src/cffc_cell.sv
// ----------------------------------------------------------------------------
// cffc_cell: one step of the conversion chain
// In the binary to BCD direction the cell adds three to each of the seven
// lower digits of five or more and shifts in the next bit. Else it folds one
// BCD byte into the binary sum while bytes remain, then passes the item on.
// ----------------------------------------------------------------------------
module cffc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   input  cffc_pkg::cell_data_type up_data,
   input  logic                    dn_enable,
   output logic                    enable,
   output logic                    valid_ff,
   output cffc_pkg::cell_data_type data_ff
);

   logic                    valid_in;
   cffc_pkg::cell_data_type data_in;
   logic [31:0]             adjusted;

   // The cell takes a new item when it is empty or its item moves on.
   assign enable   = !valid_ff || dn_enable;
   assign valid_in = enable ? up_valid : valid_ff;

   always_comb begin
      adjusted = up_data.acc;
      for (int d = 0; d < cffc_pkg::AdjDigits; d++) begin
         if (up_data.acc[d*4 +: 4] >= 4'd5) begin
            adjusted[d*4 +: 4] = up_data.acc[d*4 +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      data_in = up_data;
      if (up_data.op == cffc_pkg::OP_TO_BIN) begin
         if (up_data.bytes_left != 3'd0) begin
            data_in.acc = cffc_pkg::times100(up_data.acc)
                        + {24'd0, cffc_pkg::pair_value(up_data.value[31:24])};
            data_in.value      = {up_data.value[23:0], 8'h00};
            data_in.bytes_left = up_data.bytes_left - 3'd1;
         end
      end else begin
         data_in.acc   = {adjusted[30:0], up_data.value[cffc_pkg::CellCount-1]};
         data_in.value = {up_data.value[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

endmodule

### src/cffc_out.sv
// ----------------------------------------------------------------------------
// cffc_out: result register of the converter
// Forms the response fields from the item leaving the chain: the BCD bytes,
// the decoded frequency in hertz, or the too-large flag with zero bytes.
// ----------------------------------------------------------------------------
module cffc_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   input  cffc_pkg::cell_data_type up_data,
   output logic                    enable,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic                    rsp_tuser
);

   logic        valid_ff;
   logic        valid_in;
   logic [63:0] data_ff;
   logic [63:0] data_in;
   logic        user_ff;
   logic        user_in;

   assign enable   = !valid_ff || rsp_tready;
   assign valid_in = enable ? up_valid : valid_ff;

   always_comb begin
      data_in = 64'd0;
      user_in = 1'b0;
      if (up_data.op == cffc_pkg::OP_TO_BIN) begin
         data_in[62:32] = cffc_pkg::times10(up_data.acc[30:0]);
      end else if (up_data.too_large) begin
         user_in = 1'b1;
      end else begin
         data_in[7:0]   = up_data.acc[31:24];
         data_in[15:8]  = up_data.acc[23:16];
         data_in[23:16] = up_data.acc[15:8];
         data_in[31:24] = up_data.acc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

### src/cat_frequency_format_converter.sv
// ----------------------------------------------------------------------------
// cat_frequency_format_converter: binary / packed BCD frequency converter
// Converts a count of tens of hertz into four packed BCD bytes by double
// dabble, or four packed BCD bytes into a frequency in hertz.
//
//   channel  dir  tdata (lowest bit up)                         tuser
//   req_     in   freq_tens[31:0], bcd_in0..bcd_in3 (8 each)    op
//   rsp_     out  bcd_out0..bcd_out3 (8 each), freq_hz[62:32]   too_large
//
// A request passes 27 conversion cells and then the result register. One
// request is taken per cycle until a stalled response backs the chain up.
// There is one cell for each of the 27 shift-and-add-3 steps.
// A stalled response holds only the full cells behind it; empty cells keep
// filling, so requests are taken while a response waits until the chain is full.
// Reset clears the valid bit of every cell and of the result register.
// ----------------------------------------------------------------------------
module cat_frequency_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // freq_tens, bcd_in0, bcd_in1, bcd_in2, bcd_in3
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // bcd_out0..3, freq_hz, one zero pad bit
   output logic        rsp_tuser    // too_large
);

   localparam int N = cffc_pkg::CellCount;

   cffc_pkg::cell_data_type entry;
   logic                    cell_valid  [N];
   cffc_pkg::cell_data_type cell_data   [N];
   logic                    cell_enable [N+1];

   always_comb begin
      entry            = '0;
      entry.op         = cffc_pkg::op_type'(req_tuser);
      entry.bytes_left = 3'(cffc_pkg::BcdBytes);
      if (entry.op == cffc_pkg::OP_TO_BIN) begin
         entry.value = {req_tdata[39:32], req_tdata[47:40],
                        req_tdata[55:48], req_tdata[63:56]};
      end else begin
         entry.value     = req_tdata[31:0];
         entry.too_large = (req_tdata[31:0] >= cffc_pkg::LimitTens);
      end
   end

   assign req_tready = cell_enable[0];

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
         cffc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .up_valid  (req_tvalid),
            .up_data   (entry),
            .dn_enable (cell_enable[i+1]),
            .enable    (cell_enable[i]),
            .valid_ff  (cell_valid[i]),
            .data_ff   (cell_data[i])
         );
      end else begin : g_next
         cffc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .up_valid  (cell_valid[i-1]),
            .up_data   (cell_data[i-1]),
            .dn_enable (cell_enable[i+1]),
            .enable    (cell_enable[i]),
            .valid_ff  (cell_valid[i]),
            .data_ff   (cell_data[i])
         );
      end
   end

   cffc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (cell_valid[N-1]),
      .up_data    (cell_data[N-1]),
      .enable     (cell_enable[N]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An out-of-range count must leave all BCD bytes at zero.
   a_large_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("too_large response carries nonzero BCD bytes");

   // The flag only comes from the BCD direction, which never yields freq_hz.
   a_large_no_hz : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[62:32] == 31'd0)
      else $error("too_large response carries a frequency");

   // With no response pending the whole chain can advance.
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("requests refused while no response is pending");

   // The pad bit of the response stays zero.
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("response pad bit set");

endmodule
